[rtl/core/height_aware_lru_page_buffer_macros.svh]
// Assertion macros used by the page buffer checker, hab_checker.
// Each macro expands to one labeled concurrent assertion clocked on i_clk.
`ifndef HEIGHT_AWARE_LRU_PAGE_BUFFER_MACROS_SVH
`define HEIGHT_AWARE_LRU_PAGE_BUFFER_MACROS_SVH

// Same-cycle implication, held off during reset.
`define HAB_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("page buffer check failed");

// Next-cycle implication, held off during reset.
`define HAB_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("page buffer check failed");

`endif

[rtl/core/hab_pkg.sv]
// ----------------------------------------------------------------------------
// hab_pkg
// Shared widths, codes and cell command types for the page buffer.
// ----------------------------------------------------------------------------
package hab_pkg;

    localparam int PAGE_W      = 31;
    localparam int HGT_W       = 6;
    localparam int SLOT_W      = 6;
    localparam int CAP_W       = 7;
    localparam int KIND_W      = 2;
    localparam int CFG_DW      = 7;
    localparam int CFG_IW      = 1;
    localparam int DEF_ENTRIES = 64;

    localparam logic [KIND_W-1:0] KIND_FIND  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

    localparam logic [CFG_IW-1:0] CFG_CAPACITY    = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_TREE_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        CELL_NOP,
        CELL_PROMOTE,
        CELL_REPLACE,
        CELL_INSERT,
        CELL_CLEAR
    } t_cell_op;

    // Broadcast command to every cell
    typedef struct packed {
        t_cell_op            op;
        logic [SLOT_W-1:0]   slot;
        logic [SLOT_W-1:0]   rank;
        logic [SLOT_W-1:0]   new_rank;
        logic [PAGE_W-1:0]   page;
        logic [HGT_W-1:0]    height;
        logic                dirty;
    } t_cell_cmd;

    // Contents one cell shows to the controller
    typedef struct packed {
        logic                valid;
        logic                dirty;
        logic                match;
        logic [PAGE_W-1:0]   page;
        logic [HGT_W-1:0]    height;
        logic [SLOT_W-1:0]   rank;
    } t_cell_stat;

endpackage

[rtl/core/height_aware_lru_page_buffer.sv]
// A find or add that hits, misses at capacity zero or is an add at capacity
// zero gives its registered result straight from the look state; a new item
// may follow then. A miss walks the free slot search, or the victim scan by age
// rank when the buffer is full; a flush walks every occupied rank. The scans
// step one slot or rank a cycle through the cell row. Reset (synchronous)
// empties the table and sets capacity ENTRIES (64 by default), tree height 0.
// ----------------------------------------------------------------------------
// height_aware_lru_page_buffer
// Tag and recency side of a tree-node page buffer with height-aware eviction.
// ----------------------------------------------------------------------------
module height_aware_lru_page_buffer #(
    parameter int ENTRIES = hab_pkg::DEF_ENTRIES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [hab_pkg::KIND_W-1:0]   i_kind,
    input  logic [hab_pkg::PAGE_W-1:0]   i_page_id,
    input  logic [hab_pkg::HGT_W-1:0]    i_node_height,
    input  logic                         i_cfg_we,
    input  logic [hab_pkg::CFG_IW-1:0]   i_cfg_idx,
    input  logic [hab_pkg::CFG_DW-1:0]   i_cfg_data,
    output logic                         o_valid,
    output logic                         o_hit,
    output logic                         o_stored,
    output logic [hab_pkg::SLOT_W-1:0]   o_slot,
    output logic                         o_fetch_needed,
    output logic                         o_write_valid,
    output logic [hab_pkg::PAGE_W-1:0]   o_write_page,
    output logic                         o_write_bypass,
    output logic                         o_last
);
    import hab_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [2:0] {S_IDLE, S_LOOK, S_EVICT, S_FREE, S_FLUSH} t_state;

    t_state            r_state, n_state;
    logic [CAP_W-1:0]  r_cap, r_occ, n_occ, r_cnt, n_cnt, cap_eff;
    logic [HGT_W-1:0]  r_tree;
    logic [KIND_W-1:0] r_kind;
    logic [PAGE_W-1:0] r_page;
    logic [HGT_W-1:0]  r_height;
    logic              r_pend_v, n_pend_v;
    logic [SLOT_W-1:0] r_pend_slot, n_pend_slot;
    logic [PAGE_W-1:0] r_pend_page, n_pend_page;

    logic              r_valid, n_valid, r_hit, n_hit, r_stored, n_stored;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_fetch, n_fetch, r_wv, n_wv, r_wb, n_wb, r_last, n_last;
    logic [PAGE_W-1:0] r_wp, n_wp;

    t_cell_cmd         cmd;
    t_cell_stat        stat [ENTRIES];

    logic              hit_any, rk_any, rk_dirty, is_add, qualify;
    logic [SLOT_W-1:0] hit_slot, hit_rank, rk_slot;
    logic [HGT_W-1:0]  rk_height;
    logic [PAGE_W-1:0] rk_page;

    // Cell row
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        hab_cell #(.SLOT_IDX(g)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (cmd),
            .i_look_page(r_page),
            .o_stat     (stat[g])
        );
    end

    // Gather hit and rank-select results from the row
    always_comb begin
        hit_any   = 1'b0;
        hit_slot  = '0;
        hit_rank  = '0;
        rk_any    = 1'b0;
        rk_slot   = '0;
        rk_dirty  = 1'b0;
        rk_height = '0;
        rk_page   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (stat[i].match) begin
                hit_any  = 1'b1;
                hit_slot = hit_slot | SLOT_W'(i);
                hit_rank = hit_rank | stat[i].rank;
            end
            if (stat[i].valid && (stat[i].rank == r_cnt[SLOT_W-1:0])) begin
                rk_any    = 1'b1;
                rk_slot   = rk_slot | SLOT_W'(i);
                rk_dirty  = rk_dirty | stat[i].dirty;
                rk_height = rk_height | stat[i].height;
                rk_page   = rk_page | stat[i].page;
            end
        end
    end

    assign cap_eff = (r_cap > CAP_W'(ENTRIES)) ? CAP_W'(ENTRIES) : r_cap;
    assign is_add  = (r_kind == KIND_ADD);
    assign qualify = rk_any && ((rk_height <= r_height) || (rk_height > r_tree));

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_cnt       = r_cnt;
        n_pend_v    = r_pend_v;
        n_pend_slot = r_pend_slot;
        n_pend_page = r_pend_page;
        n_valid     = 1'b0;
        n_hit       = 1'b0;
        n_stored    = 1'b0;
        n_slot      = '0;
        n_fetch     = 1'b0;
        n_wv        = 1'b0;
        n_wp        = '0;
        n_wb        = 1'b0;
        n_last      = 1'b1;
        cmd         = '0;
        cmd.op      = CELL_NOP;
        cmd.page    = r_page;
        cmd.height  = r_height;
        cmd.dirty   = is_add;
        case (r_state)
            S_IDLE: begin
                if (i_start && (i_kind == KIND_FIND || i_kind == KIND_ADD ||
                                i_kind == KIND_FLUSH)) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_cnt = '0;
                if (r_kind == KIND_FLUSH) begin
                    n_pend_v = 1'b0;
                    n_state  = S_FLUSH;
                end else if (is_add && cap_eff == '0) begin
                    n_valid = 1'b1;
                    n_wv    = 1'b1;
                    n_wp    = r_page;
                    n_wb    = 1'b1;
                    n_state = S_IDLE;
                end else if (hit_any) begin
                    cmd.op       = CELL_PROMOTE;
                    cmd.slot     = hit_slot;
                    cmd.rank     = hit_rank;
                    cmd.new_rank = SLOT_W'(r_occ - 1'b1);
                    n_valid      = 1'b1;
                    n_hit        = 1'b1;
                    n_stored     = 1'b1;
                    n_slot       = hit_slot;
                    n_state      = S_IDLE;
                end else if (cap_eff == '0) begin
                    n_valid = 1'b1;
                    n_fetch = 1'b1;
                    n_state = S_IDLE;
                end else if (r_occ >= cap_eff) begin
                    n_state = S_EVICT;
                end else begin
                    n_state = S_FREE;
                end
            end
            S_EVICT: begin
                if (r_cnt >= r_occ) begin
                    // no evictable entry: bypass the buffer
                    n_valid = 1'b1;
                    n_fetch = !is_add;
                    n_wv    = is_add;
                    n_wp    = is_add ? r_page : '0;
                    n_wb    = is_add;
                    n_state = S_IDLE;
                end else if (qualify) begin
                    cmd.op       = CELL_REPLACE;
                    cmd.slot     = rk_slot;
                    cmd.rank     = r_cnt[SLOT_W-1:0];
                    cmd.new_rank = SLOT_W'(r_occ - 1'b1);
                    n_valid      = 1'b1;
                    n_stored     = 1'b1;
                    n_slot       = rk_slot;
                    n_fetch      = !is_add;
                    n_wv         = rk_dirty;
                    n_wp         = rk_dirty ? rk_page : '0;
                    n_state      = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FREE: begin
                if (!stat[r_cnt[IW-1:0]].valid) begin
                    cmd.op       = CELL_INSERT;
                    cmd.slot     = SLOT_W'(r_cnt[IW-1:0]);
                    cmd.new_rank = r_occ[SLOT_W-1:0];
                    n_occ        = r_occ + 1'b1;
                    n_valid      = 1'b1;
                    n_stored     = 1'b1;
                    n_slot       = SLOT_W'(r_cnt[IW-1:0]);
                    n_fetch      = !is_add;
                    n_state      = S_IDLE;
                end else if (r_cnt >= CAP_W'(ENTRIES - 1)) begin
                    n_valid = 1'b1;
                    n_fetch = !is_add;
                    n_wv    = is_add;
                    n_wp    = is_add ? r_page : '0;
                    n_wb    = is_add;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FLUSH: begin
                if (r_cnt < r_occ) begin
                    // hold one dirty page back so the final one carries last
                    if (rk_any && rk_dirty) begin
                        if (r_pend_v) begin
                            n_valid = 1'b1;
                            n_slot  = r_pend_slot;
                            n_wv    = 1'b1;
                            n_wp    = r_pend_page;
                            n_last  = 1'b0;
                        end
                        n_pend_v    = 1'b1;
                        n_pend_slot = rk_slot;
                        n_pend_page = rk_page;
                    end
                    n_cnt = r_cnt + 1'b1;
                end else begin
                    n_valid = 1'b1;
                    if (r_pend_v) begin
                        n_slot = r_pend_slot;
                        n_wv   = 1'b1;
                        n_wp   = r_pend_page;
                    end
                    cmd.op  = CELL_CLEAR;
                    n_occ   = '0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_occ    <= '0;
            r_cap    <= CAP_W'(ENTRIES);
            r_tree   <= '0;
            r_valid  <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_occ    <= n_occ;
            r_valid  <= n_valid;
            r_pend_v <= n_pend_v;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CAPACITY:    r_cap  <= i_cfg_data[CAP_W-1:0];
                    CFG_TREE_HEIGHT: r_tree <= i_cfg_data[HGT_W-1:0];
                    default: ;
                endcase
            end
        end
        if (r_state == S_IDLE && i_start) begin
            r_kind   <= i_kind;
            r_page   <= i_page_id;
            r_height <= i_node_height;
        end
        r_cnt       <= n_cnt;
        r_pend_slot <= n_pend_slot;
        r_pend_page <= n_pend_page;
        r_hit       <= n_hit;
        r_stored    <= n_stored;
        r_slot      <= n_slot;
        r_fetch     <= n_fetch;
        r_wv        <= n_wv;
        r_wp        <= n_wp;
        r_wb        <= n_wb;
        r_last      <= n_last;
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_hit          = r_hit;
    assign o_stored       = r_stored;
    assign o_slot         = r_slot;
    assign o_fetch_needed = r_fetch;
    assign o_write_valid  = r_wv;
    assign o_write_page   = r_wp;
    assign o_write_bypass = r_wb;
    assign o_last         = r_last;

endmodule

[rtl/core/hab_cell.sv]
// ----------------------------------------------------------------------------
// hab_cell
// One buffer slot: tag, height, dirty mark and age rank, with page match.
// ----------------------------------------------------------------------------
module hab_cell #(
    parameter int SLOT_IDX = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  hab_pkg::t_cell_cmd       i_cmd,
    input  logic [hab_pkg::PAGE_W-1:0] i_look_page,
    output hab_pkg::t_cell_stat      o_stat
);
    import hab_pkg::*;

    logic              r_valid;
    logic              r_dirty;
    logic [PAGE_W-1:0] r_page;
    logic [HGT_W-1:0]  r_height;
    logic [SLOT_W-1:0] r_rank;
    logic              sel;
    logic              older_gap;

    assign sel       = (i_cmd.slot == SLOT_W'(SLOT_IDX));
    assign older_gap = r_valid && (r_rank > i_cmd.rank);

    // Control bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_dirty <= 1'b0;
        end else begin
            case (i_cmd.op)
                CELL_PROMOTE: begin
                    if (sel && i_cmd.dirty) r_dirty <= 1'b1;
                end
                CELL_REPLACE: begin
                    if (sel) r_dirty <= i_cmd.dirty;
                end
                CELL_INSERT: begin
                    if (sel) begin
                        r_valid <= 1'b1;
                        r_dirty <= i_cmd.dirty;
                    end
                end
                CELL_CLEAR: begin
                    r_valid <= 1'b0;
                    r_dirty <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Payload and age rank
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            CELL_PROMOTE: begin
                if (sel)            r_rank <= i_cmd.new_rank;
                else if (older_gap) r_rank <= r_rank - 1'b1;
            end
            CELL_REPLACE: begin
                if (sel) begin
                    r_rank   <= i_cmd.new_rank;
                    r_page   <= i_cmd.page;
                    r_height <= i_cmd.height;
                end else if (older_gap) begin
                    r_rank <= r_rank - 1'b1;
                end
            end
            CELL_INSERT: begin
                if (sel) begin
                    r_rank   <= i_cmd.new_rank;
                    r_page   <= i_cmd.page;
                    r_height <= i_cmd.height;
                end
            end
            default: ;
        endcase
    end

    assign o_stat.valid  = r_valid;
    assign o_stat.dirty  = r_dirty;
    assign o_stat.match  = r_valid && (r_page == i_look_page);
    assign o_stat.page   = r_page;
    assign o_stat.height = r_height;
    assign o_stat.rank   = r_rank;

endmodule

[rtl/core/hab_checker.sv]
// ----------------------------------------------------------------------------
// hab_checker
// Port-level checks on page buffer results, bound to the top level.
// ----------------------------------------------------------------------------
`include "height_aware_lru_page_buffer_macros.svh"

module hab_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_start,
    input logic                         o_busy,
    input logic [hab_pkg::KIND_W-1:0]   i_kind,
    input logic                         o_valid,
    input logic                         o_hit,
    input logic                         o_stored,
    input logic                         o_fetch_needed,
    input logic                         o_write_valid,
    input logic                         o_write_bypass,
    input logic                         o_last
);
    import hab_pkg::*;

    // A fetch never comes with a hit
    `HAB_IMPLY(a_fetch_no_hit, o_valid && o_fetch_needed, !o_hit)
    // A hit is stored and writes nothing back
    `HAB_IMPLY(a_hit_clean, o_valid && o_hit, o_stored && !o_write_valid)
    // Write-through only for pages left out of the buffer
    `HAB_IMPLY(a_bypass, o_valid && o_write_bypass, o_write_valid && !o_stored && !o_hit)
    // Results inside a flush run are always writes
    `HAB_IMPLY(a_flush_mid, o_valid && !o_last, o_write_valid && !o_hit)
    // A known command transfer makes the block busy
    `HAB_NEXT(a_start_busy, i_start && !o_busy && (i_kind == KIND_FIND ||
        i_kind == KIND_ADD || i_kind == KIND_FLUSH), o_busy)

endmodule

bind height_aware_lru_page_buffer hab_checker u_hab_checker (.*);

[test/height_aware_lru_page_buffer_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// height_aware_lru_page_buffer_checker
// Watches the command, register and result ports of the page buffer. It keeps
// its own tag, dirty and age table, predicts the results of each accepted
// command, and compares every result strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module height_aware_lru_page_buffer_checker #(
    parameter int ENTRIES = hab_pkg::DEF_ENTRIES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_busy,
    input  logic [hab_pkg::KIND_W-1:0]   i_kind,
    input  logic [hab_pkg::PAGE_W-1:0]   i_page_id,
    input  logic [hab_pkg::HGT_W-1:0]    i_node_height,
    input  logic                         i_cfg_we,
    input  logic [hab_pkg::CFG_IW-1:0]   i_cfg_idx,
    input  logic [hab_pkg::CFG_DW-1:0]   i_cfg_data,
    input  logic                         i_valid,
    input  logic                         i_hit,
    input  logic                         i_stored,
    input  logic [hab_pkg::SLOT_W-1:0]   i_slot,
    input  logic                         i_fetch_needed,
    input  logic                         i_write_valid,
    input  logic [hab_pkg::PAGE_W-1:0]   i_write_page,
    input  logic                         i_write_bypass,
    input  logic                         i_last,
    output int                           o_fail_count,
    output int                           o_pending
);
    import hab_pkg::*;

    typedef struct {
        logic              hit;
        logic              stored;
        logic [SLOT_W-1:0] slot;
        logic              fetch;
        logic              wvalid;
        logic [PAGE_W-1:0] wpage;
        logic              bypass;
        logic              last;
    } t_access_result;

    // Shadow page table
    logic              tbl_valid  [ENTRIES];
    logic [PAGE_W-1:0] tbl_page   [ENTRIES];
    logic [HGT_W-1:0]  tbl_height [ENTRIES];
    logic              tbl_dirty  [ENTRIES];
    int                tbl_age    [ENTRIES];
    int                fill;
    int                capacity;
    int                tree_hgt;

    t_access_result    pending_results[$];

    task automatic clear_table();
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_dirty[i] = 1'b0;
            tbl_age[i]   = 0;
        end
        fill = 0;
    endtask

    task automatic push_result(logic hit, logic stored, int slot, logic fetch,
                               logic wvalid, logic [PAGE_W-1:0] wpage,
                               logic bypass, logic last);
        t_access_result r;
        r.hit = hit; r.stored = stored; r.slot = slot[SLOT_W-1:0];
        r.fetch = fetch; r.wvalid = wvalid; r.wpage = wpage;
        r.bypass = bypass; r.last = last;
        pending_results.push_back(r);
    endtask

    function automatic int slot_at_age(int age);
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && tbl_age[i] == age) return i;
        return ENTRIES;
    endfunction

    // Close the age gap left by the entry of the given age
    task automatic close_age_gap(int age);
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && tbl_age[i] > age) tbl_age[i]--;
    endtask

    task automatic predict_access(logic [KIND_W-1:0] kind, logic [PAGE_W-1:0] page,
                                  logic [HGT_W-1:0] hgt);
        int   cap;
        int   s;
        int   victim;
        int   flushed;
        logic is_add;
        logic vdirty;
        logic [PAGE_W-1:0] vpage;
        if (kind == KIND_FLUSH) begin
            flushed = 0;
            for (int a = 0; a < fill && a < ENTRIES; a++) begin
                s = slot_at_age(a);
                if (s < ENTRIES && tbl_dirty[s]) begin
                    push_result(0, 0, s, 0, 1, tbl_page[s], 0, 0);
                    flushed++;
                end
            end
            clear_table();
            if (flushed == 0) push_result(0, 0, 0, 0, 0, '0, 0, 1);
            else pending_results[pending_results.size()-1].last = 1'b1;
            return;
        end
        if (kind != KIND_FIND && kind != KIND_ADD) return;

        is_add = (kind == KIND_ADD);
        cap = (capacity > ENTRIES) ? ENTRIES : capacity;
        if (is_add && cap == 0) begin
            push_result(0, 0, 0, 0, 1, page, 1, 1);
            return;
        end
        // Hit: promote to newest
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_page[i] == page) begin
                close_age_gap(tbl_age[i]);
                tbl_age[i] = fill - 1;
                if (is_add) tbl_dirty[i] = 1'b1;
                push_result(1, 1, i, 0, 0, '0, 0, 1);
                return;
            end
        end
        if (cap == 0) begin
            push_result(0, 0, 0, 1, 0, '0, 0, 1);
            return;
        end
        if (fill >= cap) begin
            // Oldest first: lower or equal height, or taller than the tree
            victim = ENTRIES;
            for (int a = 0; a < fill && a < ENTRIES; a++) begin
                s = slot_at_age(a);
                if (s < ENTRIES && (tbl_height[s] <= hgt || tbl_height[s] > tree_hgt)) begin
                    victim = s;
                    break;
                end
            end
        end else begin
            victim = ENTRIES;
            for (int i = 0; i < ENTRIES; i++)
                if (!tbl_valid[i]) begin
                    victim = i;
                    break;
                end
        end
        if (victim < ENTRIES) begin
            vdirty = tbl_valid[victim] && tbl_dirty[victim];
            vpage  = vdirty ? tbl_page[victim] : '0;
            if (tbl_valid[victim]) begin
                tbl_valid[victim] = 1'b0;
                close_age_gap(tbl_age[victim]);
                fill--;
            end
            tbl_valid[victim]  = 1'b1;
            tbl_page[victim]   = page;
            tbl_height[victim] = hgt;
            tbl_dirty[victim]  = is_add;
            tbl_age[victim]    = fill;
            fill++;
            push_result(0, 1, victim, !is_add, vdirty, vpage, 0, 1);
        end else if (is_add) begin
            push_result(0, 0, 0, 0, 1, page, 1, 1);
        end else begin
            push_result(0, 0, 0, 1, 0, '0, 0, 1);
        end
    endtask

    task automatic compare_result();
        t_access_result e;
        if (pending_results.size() == 0) begin
            $error("result with no prediction waiting");
            o_fail_count++;
            return;
        end
        e = pending_results.pop_front();
        if (i_hit !== e.hit) begin
            $error("hit: expected %0d, actual %0d", e.hit, i_hit);
            o_fail_count++;
        end
        if (i_stored !== e.stored) begin
            $error("stored: expected %0d, actual %0d", e.stored, i_stored);
            o_fail_count++;
        end
        if (i_slot !== e.slot) begin
            $error("slot: expected %0d, actual %0d", e.slot, i_slot);
            o_fail_count++;
        end
        if (i_fetch_needed !== e.fetch) begin
            $error("fetch_needed: expected %0d, actual %0d", e.fetch, i_fetch_needed);
            o_fail_count++;
        end
        if (i_write_valid !== e.wvalid) begin
            $error("write_valid: expected %0d, actual %0d", e.wvalid, i_write_valid);
            o_fail_count++;
        end
        if (i_write_page !== e.wpage) begin
            $error("write_page: expected %0h, actual %0h", e.wpage, i_write_page);
            o_fail_count++;
        end
        if (i_write_bypass !== e.bypass) begin
            $error("write_bypass: expected %0d, actual %0d", e.bypass, i_write_bypass);
            o_fail_count++;
        end
        if (i_last !== e.last) begin
            $error("last: expected %0d, actual %0d", e.last, i_last);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        capacity     = 64;
        tree_hgt     = 0;
        clear_table();
    end

    // Track register writes, command transfers and result strobes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_table();
            capacity = 64;
            tree_hgt = 0;
            pending_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_CAPACITY) capacity = i_cfg_data;
                else if (i_cfg_idx == CFG_TREE_HEIGHT) tree_hgt = i_cfg_data[HGT_W-1:0];
            end
            if (i_start && !i_busy) predict_access(i_kind, i_page_id, i_node_height);
            if (i_valid) compare_result();
        end
        o_pending = pending_results.size();
    end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the page buffer with directed and random find, add and flush
// commands under several capacity and tree height settings, with random idle
// bursts; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import hab_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 80;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_start;
    logic                o_busy;
    logic [KIND_W-1:0]   i_kind;
    logic [PAGE_W-1:0]   i_page_id;
    logic [HGT_W-1:0]    i_node_height;
    logic                i_cfg_we;
    logic [CFG_IW-1:0]   i_cfg_idx;
    logic [CFG_DW-1:0]   i_cfg_data;
    logic                o_valid;
    logic                o_hit;
    logic                o_stored;
    logic [SLOT_W-1:0]   o_slot;
    logic                o_fetch_needed;
    logic                o_write_valid;
    logic [PAGE_W-1:0]   o_write_page;
    logic                o_write_bypass;
    logic                o_last;
    int                  fail_count;
    int                  pending;
    int                  cycle_count;
    logic                allow_gaps;
    logic [PAGE_W-1:0]   page_base;
    int                  page_span;

    height_aware_lru_page_buffer u_dut (.*);

    height_aware_lru_page_buffer_checker u_checker (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_kind, .i_page_id,
        .i_node_height, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid(o_valid), .i_hit(o_hit), .i_stored(o_stored), .i_slot(o_slot),
        .i_fetch_needed(o_fetch_needed), .i_write_valid(o_write_valid),
        .i_write_page(o_write_page), .i_write_bypass(o_write_bypass),
        .i_last(o_last), .o_fail_count(fail_count), .o_pending(pending)
    );

    // Clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Hold one command until its transfer; busy is stable while the clock is low
    task automatic issue(logic [KIND_W-1:0] kind, logic [PAGE_W-1:0] page,
                         logic [HGT_W-1:0] hgt);
        logic taken;
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            i_start = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_start = 1'b1;
        i_kind = kind;
        i_page_id = page;
        i_node_height = hgt;
        taken = 1'b0;
        while (!taken) begin
            taken = !o_busy;
            @(negedge i_clk);
        end
    endtask

    // Let every predicted result arrive, then let trailing work settle
    task automatic drain();
        i_start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Mostly pages from a small pool so hits and evictions happen
    task automatic random_access();
        logic [KIND_W-1:0] kind;
        logic [PAGE_W-1:0] page;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) kind = KIND_FIND;
        else if (pick < 90) kind = KIND_ADD;
        else if (pick < 96) kind = KIND_FLUSH;
        else kind = KIND_NONE;
        if ($urandom_range(0, 9) == 0) page = PAGE_W'($urandom);
        else page = page_base + PAGE_W'($urandom_range(0, page_span));
        issue(kind, page, HGT_W'($urandom_range(0, 63)));
    endtask

    initial begin
        cycle_count = 0;
        allow_gaps = 1'b1;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_kind = KIND_FIND;
        i_page_id = '0;
        i_node_height = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_CAPACITY;
        i_cfg_data = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty flush, extremes, hits, ignored kind
        issue(KIND_FLUSH, '0, '0);
        issue(KIND_ADD, '1, 6'd63);
        issue(KIND_FIND, '0, 6'd0);
        issue(KIND_ADD, '0, 6'd0);
        issue(KIND_FIND, '1, 6'd0);
        issue(KIND_NONE, '1, 6'd63);
        issue(KIND_FLUSH, '0, '0);
        drain();

        // Small buffer: eviction, no victim, write-through
        write_reg(CFG_CAPACITY, 7'd2);
        write_reg(CFG_TREE_HEIGHT, 7'd63);
        issue(KIND_ADD, 31'd10, 6'd40);
        issue(KIND_FIND, 31'd11, 6'd50);
        issue(KIND_ADD, 31'd12, 6'd5);
        issue(KIND_FIND, 31'd13, 6'd5);
        issue(KIND_ADD, 31'd14, 6'd63);
        issue(KIND_FIND, 31'd11, 6'd0);
        drain();

        // Capacity below occupancy, then capacity zero
        write_reg(CFG_CAPACITY, 7'd1);
        issue(KIND_ADD, 31'd20, 6'd63);
        issue(KIND_FIND, 31'd21, 6'd63);
        drain();
        write_reg(CFG_CAPACITY, 7'd0);
        issue(KIND_FIND, 31'd21, 6'd0);
        issue(KIND_FIND, 31'd22, 6'd0);
        issue(KIND_ADD, 31'd21, 6'd0);
        issue(KIND_ADD, 31'h5555_5555, 6'd21);
        issue(KIND_FLUSH, '0, '0);
        drain();

        // Random phases across settings; last phase without gaps
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_reg(CFG_CAPACITY, 7'd4);
                1: write_reg(CFG_CAPACITY, 7'd127);
                2: write_reg(CFG_CAPACITY, 7'd1);
                3: write_reg(CFG_CAPACITY, 7'd64);
                4: write_reg(CFG_CAPACITY, 7'd8);
                default: write_reg(CFG_CAPACITY, 7'($urandom_range(2, 12)));
            endcase
            case (ph)
                0: write_reg(CFG_TREE_HEIGHT, 7'd0);
                1: write_reg(CFG_TREE_HEIGHT, 7'd63);
                default: write_reg(CFG_TREE_HEIGHT, 7'($urandom_range(0, 63)));
            endcase
            page_base = PAGE_W'($urandom);
            page_span = (ph == 3) ? 80 : 3 + $urandom_range(0, 10);
            allow_gaps = (ph != 5);
            for (int n = 0; n < 30; n++) random_access();
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/hab_pkg.sv
rtl/core/hab_cell.sv
rtl/core/height_aware_lru_page_buffer.sv
rtl/core/hab_checker.sv
test/height_aware_lru_page_buffer_checker.sv
test/testbench.sv
